/* hw/rtl/rarm_pkg.sv */
`timescale 1ns / 1ps

package rarm_pkg;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_BD,
		ST_MUL_NUM,
		ST_MUL_BC,
		ST_SUM,
		ST_GCD_INIT,
		ST_GCD,
		ST_DIV_INIT,
		ST_DIV,
		ST_OUT
	} rarm_state_t;

	// Operand pair selected onto the shared multiplier.
	typedef enum logic [1:0] {
		MUL_BD,
		MUL_AD,
		MUL_AC,
		MUL_BC
	} rarm_mul_sel_t;

	// Action codes carried in the input tuser.
	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_MUL = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic          load;
		logic          mul_en;
		rarm_mul_sel_t mul_sel;
		logic          den_cap;
		logic          num_cap;
		logic          num_acc;
		logic          gcd_init;
		logic          gcd_step;
		logic          div_init;
		logic          div_step;
	} rarm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_empty;
		logic is_mul;
		logic gcd_done;
		logic div_done;
	} rarm_status_t;

endpackage

/* hw/rtl/rarm_ctrl.sv */
`timescale 1ns / 1ps

module rarm_ctrl
	import rarm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  rarm_status_t status,
	output rarm_cmd_t    cmd
);

	rarm_state_t state_q;
	rarm_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.mul_sel = MUL_BD;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.in_empty ? ST_OUT : ST_MUL_BD;
				end
			end
			ST_MUL_BD: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_BD;
				state_d     = ST_MUL_NUM;
			end
			ST_MUL_NUM: begin
				cmd.den_cap = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = status.is_mul ? MUL_AC : MUL_AD;
				state_d     = ST_MUL_BC;
			end
			ST_MUL_BC: begin
				cmd.num_cap = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_BC;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				cmd.num_acc = !status.is_mul;
				state_d     = ST_GCD_INIT;
			end
			ST_GCD_INIT: begin
				cmd.gcd_init = 1'b1;
				state_d      = ST_GCD;
			end
			ST_GCD: begin
				if (status.gcd_done) begin
					state_d = ST_DIV_INIT;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/rarm_datapath.sv */
`timescale 1ns / 1ps

module rarm_datapath
	import rarm_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rarm_cmd_t                  cmd,
	input  logic                       in_action,
	input  logic [OPERAND_WIDTH-1:0]   in_left_num,
	input  logic [OPERAND_WIDTH-1:0]   in_left_den,
	input  logic [OPERAND_WIDTH-1:0]   in_right_num,
	input  logic [OPERAND_WIDTH-1:0]   in_right_den,
	output rarm_status_t               status,
	output logic [2*OPERAND_WIDTH:0]   result_num,
	output logic [2*OPERAND_WIDTH-1:0] result_den,
	output logic                       is_empty
);

	localparam int W  = OPERAND_WIDTH;
	localparam int NW = 2 * W + 1;
	localparam int KW = $clog2(2 * W + 1);
	localparam int CW = $clog2(NW);

	logic [W-1:0]    a_q, b_q, c_q, d_q;
	logic            op_q;
	logic            empty_q;
	logic [2*W-1:0]  prod_q;
	logic [NW-1:0]   num_q;
	logic [2*W-1:0]  den_q;
	logic [NW-1:0]   x_q, y_q;
	logic [KW-1:0]   k_q;
	logic [NW-1:0]   g_q;
	logic [NW-1:0]   qn_q, qd_q;
	logic [NW-1:0]   rn_q, rd_q;
	logic [CW-1:0]   cnt_q;

	logic [W-1:0]    mul_a, mul_b;
	logic [NW:0]     rn_sh, rd_sh;
	logic            rn_ge, rd_ge;

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cmd.mul_sel)
			MUL_BD:  begin mul_a = b_q; mul_b = d_q; end
			MUL_AD:  begin mul_a = a_q; mul_b = d_q; end
			MUL_AC:  begin mul_a = a_q; mul_b = c_q; end
			MUL_BC:  begin mul_a = b_q; mul_b = c_q; end
			default: begin mul_a = b_q; mul_b = d_q; end
		endcase
	end

	// Restoring division of numerator and denominator by the common divisor.
	assign rn_sh = {rn_q, qn_q[NW-1]};
	assign rd_sh = {rd_q, qd_q[NW-1]};
	assign rn_ge = rn_sh >= {1'b0, g_q};
	assign rd_ge = rd_sh >= {1'b0, g_q};

	// Control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.gcd_init) begin
				k_q <= '0;
			end else if (cmd.gcd_step && !x_q[0] && !y_q[0]) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Operand capture, products, binary GCD and division registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q     <= in_left_num;
			b_q     <= in_left_den;
			c_q     <= in_right_num;
			d_q     <= in_right_den;
			op_q    <= in_action;
			empty_q <= status.in_empty;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.den_cap) begin
			den_q <= prod_q;
		end
		if (cmd.num_cap) begin
			num_q <= {1'b0, prod_q};
		end else if (cmd.num_acc) begin
			num_q <= num_q + {1'b0, prod_q};
		end
		if (cmd.gcd_init) begin
			x_q <= num_q;
			y_q <= {1'b0, den_q};
		end else if (cmd.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= x_q - y_q;
			end else begin
				y_q <= y_q - x_q;
			end
		end
		if (cmd.div_init) begin
			g_q  <= (x_q | y_q) << k_q;
			qn_q <= num_q;
			qd_q <= {1'b0, den_q};
			rn_q <= '0;
			rd_q <= '0;
		end else if (cmd.div_step) begin
			rn_q <= rn_ge ? NW'(rn_sh - {1'b0, g_q}) : rn_sh[NW-1:0];
			rd_q <= rd_ge ? NW'(rd_sh - {1'b0, g_q}) : rd_sh[NW-1:0];
			qn_q <= {qn_q[NW-2:0], rn_ge};
			qd_q <= {qd_q[NW-2:0], rd_ge};
		end
	end

	// Status toward the controller.
	assign status.in_empty = (in_left_num == '0) || (in_left_den == '0) ||
	                         (in_right_num == '0) || (in_right_den == '0);
	assign status.is_mul   = (op_q == ACT_MUL);
	assign status.gcd_done = (x_q == '0) || (y_q == '0);
	assign status.div_done = (cnt_q == CW'(NW - 1));

	// Result fields; an empty operand gives 0/0.
	assign result_num = empty_q ? '0 : qn_q;
	assign result_den = empty_q ? '0 : qd_q[2*W-1:0];
	assign is_empty   = empty_q;

endmodule

/* hw/rtl/rational_add_multiply_reduce_top.sv */
`timescale 1ns / 1ps
// An item with an empty operand is offered in the cycle after its transfer.
// Otherwise the result is offered after the products, the sum, the binary GCD steps
// and the bit-serial divisions of numerator and denominator by the common divisor.
// One item is handled at a time; a new item is taken after the result transfer.
// Reset: arst_n asynchronously clears the controller to idle; no result pending.

module rational_add_multiply_reduce_top
	import rarm_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// left_num, left_den, right_num, right_den (lowest bits first), zero padded
	input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	// action
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// result_num, result_den (lowest bits first), zero padded
	output logic [((4*OPERAND_WIDTH+1+7)/8)*8-1:0] m_axis_tdata,
	// is_empty
	output logic m_axis_tuser
);

	localparam int W   = OPERAND_WIDTH;
	localparam int ODW = ((4 * W + 1 + 7) / 8) * 8;

	rarm_cmd_t    cmd;
	rarm_status_t status;
	logic [2*W:0]   result_num;
	logic [2*W-1:0] result_den;
	logic           is_empty;

	// Sequencer.
	rarm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic.
	rarm_datapath #(
		.OPERAND_WIDTH(W)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_action    (s_axis_tuser),
		.in_left_num  (s_axis_tdata[W-1:0]),
		.in_left_den  (s_axis_tdata[2*W-1:W]),
		.in_right_num (s_axis_tdata[3*W-1:2*W]),
		.in_right_den (s_axis_tdata[4*W-1:3*W]),
		.status       (status),
		.result_num   (result_num),
		.result_den   (result_den),
		.is_empty     (is_empty)
	);

	// Output packing.
	assign m_axis_tdata = ODW'({result_den, result_num});
	assign m_axis_tuser = is_empty;

`ifndef SYNTH
	// No item is taken while a result is offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while result pending");

	// An empty result is 0/0.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (result_num == '0 && result_den == '0))
		else $error("empty result not zero");

	// A non-empty result has nonzero terms.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (result_num != '0 && result_den != '0))
		else $error("non-empty result has a zero term");
`endif

endmodule
